@@ rtl/assert_macros.svh @@
// Assertion macros used by the subnet host monitor RTL.
// Standalone header; files that assert take it in with an include line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every edge outside reset.
`define SUHM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be seen outside reset.
`define SUHM_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define SUHM_ASSERT(lbl, clk, rst_n, prop)
`define SUHM_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ rtl/suhm_pkg.sv @@
// Package for the subnet unique-host monitor: widths, register indexes,
// prefix record type and prefix helper functions. No dependencies.
`default_nettype none

package suhm_pkg;

  localparam int NumPrefix    = 4;
  localparam int AddrW        = 32;
  localparam int LenW         = 6;
  localparam int CountW       = 11;
  localparam int CfgW         = 38;
  localparam int CfgIdxW      = 3;
  localparam int InUseW       = 3;
  localparam int DefSeenDepth = 1024;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [LenW-1:0]   MaxLen   = 6'd32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PREFIX_A = 3'd0,
    REG_PREFIX_B = 3'd1,
    REG_PREFIX_C = 3'd2,
    REG_PREFIX_D = 3'd3,
    REG_IN_USE   = 3'd4
  } reg_idx_e;

  // Same packing as the configuration word: base above, length below.
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  len;
  } prefix_t;

  // Counter update request from the sequencer.
  typedef struct packed {
    logic                 en;
    logic [NumPrefix-1:0] mask;
  } upd_t;

  // Status returned by the counter unit.
  typedef struct packed {
    logic                 halted;
    logic [NumPrefix-1:0] alert;
  } cnt_stat_t;

  function automatic logic [LenW-1:0] prefix_len(input logic [LenW-1:0] len);
    prefix_len = (len > MaxLen) ? MaxLen : len;
  endfunction

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [LenW-1:0] l;
    l = prefix_len(len);
    if (l == '0) begin
      prefix_mask = '0;
    end else begin
      prefix_mask = {AddrW{1'b1}} << (MaxLen - l);
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/suhm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module suhm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/suhm_match.sv @@
// Prefix match stage: compares one address against the active prefixes and
// registers the hit mask. Depends on suhm_pkg.
`default_nettype none

module suhm_match (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [suhm_pkg::AddrW-1:0]             addr_i,
  input  wire suhm_pkg::prefix_t [suhm_pkg::NumPrefix-1:0] prefix_i,
  input  wire logic [suhm_pkg::InUseW-1:0]            in_use_i,
  output logic      [suhm_pkg::NumPrefix-1:0]         match_o
);

  logic [suhm_pkg::NumPrefix-1:0] match_d;

  always_comb begin
    for (int k = 0; k < suhm_pkg::NumPrefix; k++) begin
      logic [suhm_pkg::AddrW-1:0] m;
      m = suhm_pkg::prefix_mask(prefix_i[k].len);
      // slots at or above the in-use count stay dark; larger counts enable all
      match_d[k] = (in_use_i > suhm_pkg::InUseW'(k)) &&
                   ((addr_i & m) == (prefix_i[k].base & m));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      match_o <= match_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/suhm_count.sv @@
// Host counters, one-time alert flags and the halt flag, updated once per new
// host. Depends on suhm_pkg.
`default_nettype none

module suhm_count (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire suhm_pkg::upd_t                              upd_i,
  input  wire suhm_pkg::prefix_t [suhm_pkg::NumPrefix-1:0] prefix_i,
  output suhm_pkg::cnt_stat_t                              stat_o,
  output logic [suhm_pkg::NumPrefix-1:0][suhm_pkg::CountW-1:0] count_o
);

  logic [suhm_pkg::NumPrefix-1:0][suhm_pkg::CountW-1:0] cnt_q, cnt_inc;
  logic [suhm_pkg::NumPrefix-1:0] sent_q;
  logic [suhm_pkg::NumPrefix-1:0] full_hit, alert_hit;
  logic                           halted_q;

  always_comb begin
    for (int k = 0; k < suhm_pkg::NumPrefix; k++) begin
      logic [suhm_pkg::LenW-1:0] l;
      logic [32:0]               cap, used, twice;
      l          = suhm_pkg::prefix_len(prefix_i[k].len);
      cnt_inc[k] = (cnt_q[k] == suhm_pkg::CountMax) ? cnt_q[k] : cnt_q[k] + 1'b1;
      // capacity 2^(32-len)-2; a /32 has no capacity and is skipped
      cap   = (33'd1 << (suhm_pkg::MaxLen - l)) - 33'd2;
      used  = 33'(cnt_inc[k]);
      twice = 33'({cnt_inc[k], 1'b0});
      full_hit[k]  = upd_i.mask[k] && (l != suhm_pkg::MaxLen) && (used >= cap);
      alert_hit[k] = upd_i.mask[k] && (l != suhm_pkg::MaxLen) && (twice > cap) &&
                     !sent_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sent_q   <= '0;
      halted_q <= 1'b0;
    end else if (upd_i.en) begin
      for (int k = 0; k < suhm_pkg::NumPrefix; k++) begin
        if (upd_i.mask[k]) begin
          cnt_q[k] <= cnt_inc[k];
        end
      end
      sent_q   <= sent_q | alert_hit;
      halted_q <= halted_q | (|full_hit);
    end
  end

  assign stat_o.halted = halted_q;
  assign stat_o.alert  = alert_hit;
  assign count_o       = cnt_q;

endmodule

`default_nettype wire

@@ rtl/subnet_unique_host_monitor.sv @@
// Subnet unique-host monitor, top level: sequencer, config registers and
// output register. Depends on suhm_pkg, suhm_ram, suhm_match, suhm_count.
//
// Usage: one source address per input transfer (in_valid_i / in_stall_o);
// one result per address on the output channel (out_valid_o / out_stall_i),
// carrying the new-host and alert masks, full and overflow flags and the four
// host counts. Prefixes are set through the write port; the user must write
// them only while the block idles, as the block itself does not enforce it.
// An address matching no prefix, or any address once halted, passes from
// ST_MATCH through ST_CHECK to ST_RESP; a matching one walks the seen store,
// one entry a cycle through its single read port, up to the fill level. One
// address is in flight at a time; the next is taken once the previous result
// sits in the output register. A result stalled by out_stall_i holds in the
// output register; the next address is still accepted and worked on, and
// waits before its own result only if the register is still occupied.
// Reset clears counts, alert flags, the halt flag, the store fill level and
// the configuration (one active prefix, all bases and lengths zero). The
// store contents are not cleared; only entries below the fill level are read.
// Once a prefix fills, every later result reports full and the counts freeze.
`default_nettype none
`include "assert_macros.svh"

module subnet_unique_host_monitor #(
  parameter int SEEN_DEPTH = suhm_pkg::DefSeenDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [suhm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [suhm_pkg::CfgW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [suhm_pkg::AddrW-1:0]        source_address_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [suhm_pkg::NumPrefix-1:0]         new_host_mask_o,
  output logic [suhm_pkg::NumPrefix-1:0]         alert_mask_o,
  output logic                                   full_flag_o,
  output logic                                   overflow_flag_o,
  output logic [suhm_pkg::CountW-1:0]            used_a_o,
  output logic [suhm_pkg::CountW-1:0]            used_b_o,
  output logic [suhm_pkg::CountW-1:0]            used_c_o,
  output logic [suhm_pkg::CountW-1:0]            used_d_o
);

  localparam int IdxW  = $clog2(SEEN_DEPTH);
  localparam int FillW = $clog2(SEEN_DEPTH + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(SEEN_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_CHECK,
    ST_SEARCH,
    ST_NEW,
    ST_RESP
  } state_e;

  // configuration
  suhm_pkg::prefix_t [suhm_pkg::NumPrefix-1:0] prefix_q;
  logic [suhm_pkg::InUseW-1:0]                 in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      in_use_q <= suhm_pkg::InUseW'(1);
    end else if (cfg_we_i) begin
      case (suhm_pkg::reg_idx_e'(cfg_idx_i))
        suhm_pkg::REG_PREFIX_A: prefix_q[0] <= suhm_pkg::prefix_t'(cfg_data_i);
        suhm_pkg::REG_PREFIX_B: prefix_q[1] <= suhm_pkg::prefix_t'(cfg_data_i);
        suhm_pkg::REG_PREFIX_C: prefix_q[2] <= suhm_pkg::prefix_t'(cfg_data_i);
        suhm_pkg::REG_PREFIX_D: prefix_q[3] <= suhm_pkg::prefix_t'(cfg_data_i);
        suhm_pkg::REG_IN_USE:   in_use_q    <= cfg_data_i[suhm_pkg::InUseW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e                          state_q, state_d;
  logic [suhm_pkg::AddrW-1:0]      addr_q, addr_d;
  logic [FillW-1:0]                fill_q, fill_d;
  logic [FillW-1:0]                rd_idx_q, rd_idx_d;
  logic [suhm_pkg::NumPrefix-1:0]  res_new_q, res_new_d, res_alert_q, res_alert_d;
  logic                            res_ovf_q, res_ovf_d;
  logic                            out_valid_q, out_valid_d;
  logic [suhm_pkg::NumPrefix-1:0]  out_new_q, out_new_d, out_alert_q, out_alert_d;
  logic                            out_full_q, out_full_d, out_ovf_q, out_ovf_d;
  logic [suhm_pkg::NumPrefix-1:0][suhm_pkg::CountW-1:0] out_used_q, out_used_d;

  logic                            ram_re, ram_we;
  logic [IdxW-1:0]                 ram_raddr;
  logic [suhm_pkg::AddrW-1:0]      ram_rdata;
  logic                            match_en;
  logic [suhm_pkg::NumPrefix-1:0]  match;
  suhm_pkg::upd_t                  upd;
  suhm_pkg::cnt_stat_t             stat;
  logic [suhm_pkg::NumPrefix-1:0][suhm_pkg::CountW-1:0] counts;

  suhm_ram #(
    .Width(suhm_pkg::AddrW),
    .Depth(SEEN_DEPTH)
  ) u_seen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[IdxW-1:0]),
    .wdata_i(addr_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  suhm_match u_match (
    .clk_i   (clk_i),
    .en_i    (match_en),
    .addr_i  (addr_q),
    .prefix_i(prefix_q),
    .in_use_i(in_use_q),
    .match_o (match)
  );

  suhm_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .prefix_i(prefix_q),
    .stat_o  (stat),
    .count_o (counts)
  );

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    res_new_d   = res_new_q;
    res_alert_d = res_alert_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q;
    out_new_d   = out_new_q;
    out_alert_d = out_alert_q;
    out_full_d  = out_full_q;
    out_ovf_d   = out_ovf_q;
    out_used_d  = out_used_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = '0;
    match_en    = 1'b0;
    upd.en      = 1'b0;
    upd.mask    = match;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          addr_d  = source_address_i;
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        match_en = 1'b1;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        res_new_d   = '0;
        res_alert_d = '0;
        res_ovf_d   = 1'b0;
        if (stat.halted || (match == '0)) begin
          state_d = ST_RESP;
        end else if (fill_q == '0) begin
          state_d = ST_NEW;
        end else begin
          ram_re   = 1'b1;
          rd_idx_d = FillW'(1);
          state_d  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // read data belongs to the entry issued last cycle
        if (ram_rdata == addr_q) begin
          state_d = ST_RESP;
        end else if (rd_idx_q != fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[IdxW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else begin
          state_d = ST_NEW;
        end
      end
      ST_NEW: begin
        if (fill_q == FillFull) begin
          res_ovf_d = 1'b1;
        end else begin
          ram_we      = 1'b1;
          fill_d      = fill_q + 1'b1;
          upd.en      = 1'b1;
          res_new_d   = match;
          res_alert_d = stat.alert;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_new_d   = res_new_q;
          out_alert_d = res_alert_q;
          out_full_d  = stat.halted;
          out_ovf_d   = res_ovf_q;
          out_used_d  = counts;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      res_new_q   <= '0;
      res_alert_q <= '0;
      res_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_new_q   <= '0;
      out_alert_q <= '0;
      out_full_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_used_q  <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      res_new_q   <= res_new_d;
      res_alert_q <= res_alert_d;
      res_ovf_q   <= res_ovf_d;
      out_valid_q <= out_valid_d;
      out_new_q   <= out_new_d;
      out_alert_q <= out_alert_d;
      out_full_q  <= out_full_d;
      out_ovf_q   <= out_ovf_d;
      out_used_q  <= out_used_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_host_mask_o = out_new_q;
  assign alert_mask_o    = out_alert_q;
  assign full_flag_o     = out_full_q;
  assign overflow_flag_o = out_ovf_q;
  assign used_a_o        = out_used_q[0];
  assign used_b_o        = out_used_q[1];
  assign used_c_o        = out_used_q[2];
  assign used_d_o        = out_used_q[3];

  `SUHM_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > FillFull)
  `SUHM_ASSERT(a_halt_sticky, clk_i, rst_ni, stat.halted |=> stat.halted)
  `SUHM_ASSERT(a_store_grows, clk_i, rst_ni, ram_we |=> fill_q == $past(fill_q) + 1'b1)
  `SUHM_NEVER(a_ovf_no_new, clk_i, rst_ni, out_valid_q && out_ovf_q && (out_new_q != '0))

endmodule

`default_nettype wire
